/* rtl/core/jgr_pkg.sv */
// Shared constants, types and codes of the Jacobi grid relaxation block.
package jgr_pkg;

  localparam int GRID_MAX   = 64;
  localparam int VALUE_BITS = 32;

  localparam int CELLS      = GRID_MAX * GRID_MAX;
  localparam int ADDR_W     = $clog2(CELLS);
  localparam int COORD_W    = $clog2(GRID_MAX);
  localparam int SIZE_W     = $clog2(GRID_MAX + 1);
  localparam int Y_W        = $clog2(GRID_MAX + 2);
  localparam int CNT_W      = $clog2(CELLS + GRID_MAX + 1);

  localparam int FUNC_W     = 2;
  localparam int ROWCOL_W   = 6;
  localparam int DATA_W     = 32;
  localparam int GS_W       = 7;
  localparam int PREC_W     = 31;
  localparam int COUNT_W    = 16;
  localparam int CFG_ADDR_W = 2;
  localparam int SIZE_MIN   = 3;
  localparam int CMP_W      = (VALUE_BITS > PREC_W) ? VALUE_BITS : PREC_W;

  localparam logic [CFG_ADDR_W-1:0] CfgGridSize  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CfgBoundary  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CfgPrecision = 2'd2;

  localparam logic [GS_W-1:0]          GridSizeReset  = 7'd5;
  localparam logic signed [DATA_W-1:0] BoundaryReset  = 32'sd65536;
  localparam logic [PREC_W-1:0]        PrecisionReset = 31'd655;

  typedef logic signed [VALUE_BITS-1:0] cell_t;

  typedef enum logic [FUNC_W-1:0] {
    FuncInit  = 2'd0,
    FuncSweep = 2'd1,
    FuncRead  = 2'd2
  } func_e;

  typedef enum logic [2:0] {
    StIdle,
    StInit,
    StSweep,
    StDrain,
    StRdWait,
    StResp
  } state_e;

  // One sample of the sweep stream and the cell whose stencil it completes.
  typedef struct packed {
    logic               valid;
    logic [COORD_W-1:0] col;
    logic               ctr_ok;
    logic [COORD_W-1:0] cy;
    logic [COORD_W-1:0] cx;
    logic [ADDR_W-1:0]  caddr;
    logic               last;
  } beat_t;

  // Write-back of one relaxed cell into the destination store.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    cell_t             data;
    logic              change;
    logic              last;
  } wr_t;

endpackage

/* rtl/core/jgr_cmd_if.sv */
// Command channel: function code and cell coordinates.
interface jgr_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [jgr_pkg::FUNC_W-1:0]    func;
  logic [jgr_pkg::ROWCOL_W-1:0]  row;
  logic [jgr_pkg::ROWCOL_W-1:0]  col;

  modport source (output valid, output func, output row, output col, input ready);
  modport sink (input valid, input func, input row, input col, output ready);
endinterface

/* rtl/core/jgr_res_if.sv */
// Result channel: cell value, convergence flag and sweep count.
interface jgr_res_if;
  logic                          valid;
  logic                          ready;
  logic [jgr_pkg::DATA_W-1:0]    cell_value;
  logic                          converged;
  logic [jgr_pkg::COUNT_W-1:0]   sweep_count;

  modport source (output valid, output cell_value, output converged, output sweep_count,
                  input ready);
  modport sink (input valid, input cell_value, input converged, input sweep_count,
                output ready);
endinterface

/* rtl/core/jgr_ram.sv */
// Generic simple dual-port RAM with registered read (read-first on collision).
module jgr_ram #(
  parameter int Width = 32,
  parameter int Depth = 64,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/jgr_stencil.sv */
// Five-point stencil pipeline: two row line buffers, a sliding window and write-back.
module jgr_stencil (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  jgr_pkg::beat_t              beat_i,
  input  jgr_pkg::cell_t              data_i,
  input  logic [jgr_pkg::SIZE_W-1:0]  size_i,
  input  logic [jgr_pkg::PREC_W-1:0]  prec_i,
  output jgr_pkg::wr_t                wr_o
);

  typedef logic signed [jgr_pkg::VALUE_BITS+1:0] sum_t;
  typedef logic signed [jgr_pkg::VALUE_BITS:0]   diff_t;

  jgr_pkg::beat_t b2_q, b3_q, b4_q, b5_q;
  jgr_pkg::cell_t s2_q, s3_q, a3_q;
  jgr_pkg::cell_t lb1_rdata, lb2_rdata;
  jgr_pkg::cell_t w_bot0_q, w_bot_q, w_r_q, w_c_q, w_l_q, w_top0_q, w_top_q;
  jgr_pkg::cell_t new5_q, old5_q;
  logic           int5_q;

  sum_t           sum;
  jgr_pkg::cell_t mean;
  logic           interior;
  diff_t          dsub;
  diff_t          dabs;
  logic           big;

  // First line buffer delays the stream by one grid row, the second by another.
  jgr_ram #(.Width(jgr_pkg::VALUE_BITS), .Depth(jgr_pkg::GRID_MAX)) u_lb1 (
    .clk_i   (clk_i),
    .we_i    (beat_i.valid),
    .waddr_i (beat_i.col),
    .wdata_i (data_i),
    .raddr_i (beat_i.col),
    .rdata_o (lb1_rdata)
  );

  jgr_ram #(.Width(jgr_pkg::VALUE_BITS), .Depth(jgr_pkg::GRID_MAX)) u_lb2 (
    .clk_i   (clk_i),
    .we_i    (b2_q.valid),
    .waddr_i (b2_q.col),
    .wdata_i (lb1_rdata),
    .raddr_i (b2_q.col),
    .rdata_o (lb2_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b2_q <= '0;
      b3_q <= '0;
      b4_q <= '0;
      b5_q <= '0;
    end else begin
      b2_q <= beat_i;
      b3_q <= b2_q;
      b4_q <= b3_q;
      b5_q <= b4_q;
    end
  end

  // After a shift the window is centered one row and one column behind the newest sample.
  always_ff @(posedge clk_i) begin
    s2_q <= data_i;
    s3_q <= s2_q;
    a3_q <= lb1_rdata;
    if (b3_q.valid) begin
      w_bot0_q <= s3_q;
      w_bot_q  <= w_bot0_q;
      w_r_q    <= a3_q;
      w_c_q    <= w_r_q;
      w_l_q    <= w_c_q;
      w_top0_q <= lb2_rdata;
      w_top_q  <= w_top0_q;
    end
    new5_q <= interior ? mean : w_c_q;
    old5_q <= w_c_q;
    int5_q <= interior;
  end

  always_comb begin
    sum  = sum_t'(w_l_q) + sum_t'(w_top_q) + sum_t'(w_r_q) + sum_t'(w_bot_q);
    // Arithmetic shift of the exact sum gives the floor of the mean.
    mean = sum[jgr_pkg::VALUE_BITS+1:2];
    interior = b4_q.ctr_ok && (b4_q.cy != '0) && (b4_q.cx != '0) &&
               ((jgr_pkg::SIZE_W'(b4_q.cy) + jgr_pkg::SIZE_W'(1)) < size_i) &&
               ((jgr_pkg::SIZE_W'(b4_q.cx) + jgr_pkg::SIZE_W'(1)) < size_i);
  end

  always_comb begin
    dsub = diff_t'(new5_q) - diff_t'(old5_q);
    dabs = dsub[jgr_pkg::VALUE_BITS] ? -dsub : dsub;
    big  = jgr_pkg::CMP_W'(dabs[jgr_pkg::VALUE_BITS-1:0]) >= jgr_pkg::CMP_W'(prec_i);

    wr_o.we     = b5_q.valid && b5_q.ctr_ok;
    wr_o.addr   = b5_q.caddr;
    wr_o.data   = new5_q;
    wr_o.change = b5_q.valid && b5_q.ctr_ok && int5_q && big;
    wr_o.last   = b5_q.valid && b5_q.last;
  end

endmodule

/* rtl/core/jacobi_grid_relaxation.sv */
// Jacobi relaxation of a square Laplace grid held in two ping-pong grid memories.
// Initialise: one write per cell in both stores.
// Sweep: every cell is streamed once through the read port of the source store.
// One command is worked on at a time; the next is taken while a result waits to be taken.
// Reset clears control, counters and flags and loads the register defaults; grid contents
// stay undefined until the first initialise.
module jacobi_grid_relaxation (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [jgr_pkg::CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [jgr_pkg::DATA_W-1:0]      cfg_wdata_i,
  jgr_cmd_if.sink                         cmd_i,
  jgr_res_if.source                       res_o
);

  jgr_pkg::state_e state_q, state_d;

  logic                          cur_q;
  logic [jgr_pkg::COUNT_W-1:0]   sweeps_q;
  logic                          settled_q;
  logic                          acc_q;
  logic [jgr_pkg::GS_W-1:0]      gs_q;
  logic signed [jgr_pkg::DATA_W-1:0] bnd_q;
  logic [jgr_pkg::PREC_W-1:0]    prec_q;

  logic [jgr_pkg::CNT_W-1:0]     cnt_q;
  logic [jgr_pkg::COORD_W-1:0]   x_q;
  logic [jgr_pkg::Y_W-1:0]       y_q;

  logic                          rd_ok_q;
  logic [jgr_pkg::DATA_W-1:0]    cell_q;
  logic                          out_valid_q;
  logic [jgr_pkg::DATA_W-1:0]    out_cell_q;
  logic                          out_conv_q;
  logic [jgr_pkg::COUNT_W-1:0]   out_count_q;

  jgr_pkg::beat_t                beat_d, beat_q;
  jgr_pkg::wr_t                  wr;

  logic [jgr_pkg::SIZE_W-1:0]    size_n;
  logic                          cmd_fire;
  logic                          init_we;
  logic                          issue;
  logic                          out_load;
  logic                          init_last;
  logic                          issue_last;
  logic                          rd_range;

  logic [jgr_pkg::ADDR_W-1:0]    rd_addr;
  logic [jgr_pkg::ADDR_W-1:0]    src_addr;
  logic [jgr_pkg::ADDR_W-1:0]    raddr;
  logic [jgr_pkg::ADDR_W-1:0]    waddr;
  jgr_pkg::cell_t                wdata;
  jgr_pkg::cell_t                init_val;
  logic                          we_a, we_b;
  jgr_pkg::cell_t                rdata_a, rdata_b, rdata_cur;

  assign cmd_fire   = cmd_i.valid && cmd_i.ready;
  assign init_last  = (cnt_q == jgr_pkg::CNT_W'(jgr_pkg::CELLS - 1));
  assign issue_last = (cnt_q == jgr_pkg::CNT_W'(jgr_pkg::CELLS + jgr_pkg::GRID_MAX));
  assign rdata_cur  = cur_q ? rdata_b : rdata_a;

  always_comb begin
    if (32'(gs_q) < jgr_pkg::SIZE_MIN) begin
      size_n = jgr_pkg::SIZE_W'(jgr_pkg::SIZE_MIN);
    end else if (32'(gs_q) > jgr_pkg::GRID_MAX) begin
      size_n = jgr_pkg::SIZE_W'(jgr_pkg::GRID_MAX);
    end else begin
      size_n = jgr_pkg::SIZE_W'(gs_q);
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      jgr_pkg::StIdle: begin
        if (cmd_fire) begin
          case (cmd_i.func)
            jgr_pkg::FuncInit:  state_d = jgr_pkg::StInit;
            jgr_pkg::FuncSweep: state_d = jgr_pkg::StSweep;
            jgr_pkg::FuncRead:  state_d = jgr_pkg::StRdWait;
            default:            state_d = jgr_pkg::StResp;
          endcase
        end
      end
      jgr_pkg::StInit: begin
        if (init_last) state_d = jgr_pkg::StResp;
      end
      jgr_pkg::StSweep: begin
        if (issue_last) state_d = jgr_pkg::StDrain;
      end
      jgr_pkg::StDrain: begin
        if (wr.last) state_d = jgr_pkg::StResp;
      end
      jgr_pkg::StRdWait: begin
        state_d = jgr_pkg::StResp;
      end
      jgr_pkg::StResp: begin
        if (!out_valid_q || res_o.ready) state_d = jgr_pkg::StIdle;
      end
      default: begin
        state_d = jgr_pkg::StIdle;
      end
    endcase
  end

  // State outputs.
  always_comb begin
    cmd_i.ready = 1'b0;
    init_we     = 1'b0;
    issue       = 1'b0;
    out_load    = 1'b0;
    case (state_q)
      jgr_pkg::StIdle:  cmd_i.ready = 1'b1;
      jgr_pkg::StInit:  init_we = 1'b1;
      jgr_pkg::StSweep: issue = 1'b1;
      jgr_pkg::StResp:  out_load = !out_valid_q || res_o.ready;
      default: begin
      end
    endcase
  end

  // Stream beat: the sample read now and the cell one row and one column behind it.
  always_comb begin
    beat_d.valid  = issue;
    beat_d.col    = x_q;
    beat_d.ctr_ok = cnt_q >= jgr_pkg::CNT_W'(jgr_pkg::GRID_MAX + 1);
    if (x_q == '0) begin
      beat_d.cx = jgr_pkg::COORD_W'(jgr_pkg::GRID_MAX - 1);
      beat_d.cy = jgr_pkg::COORD_W'(y_q - jgr_pkg::Y_W'(2));
    end else begin
      beat_d.cx = x_q - 1'b1;
      beat_d.cy = jgr_pkg::COORD_W'(y_q - jgr_pkg::Y_W'(1));
    end
    beat_d.caddr = jgr_pkg::ADDR_W'(cnt_q - jgr_pkg::CNT_W'(jgr_pkg::GRID_MAX + 1));
    beat_d.last  = issue_last;
  end

  always_comb begin
    rd_addr  = jgr_pkg::ADDR_W'(32'(cmd_i.row) * jgr_pkg::GRID_MAX + 32'(cmd_i.col));
    rd_range = (32'(cmd_i.row) < 32'(size_n)) && (32'(cmd_i.col) < 32'(size_n));
    // Past the last cell the stream only flushes the window; the data read is unused.
    src_addr = (cnt_q < jgr_pkg::CNT_W'(jgr_pkg::CELLS)) ? jgr_pkg::ADDR_W'(cnt_q) : '0;
    raddr    = issue ? src_addr : rd_addr;
    init_val = ((y_q == '0) || (x_q == '0)) ? jgr_pkg::cell_t'(bnd_q) : '0;
    waddr    = init_we ? jgr_pkg::ADDR_W'(cnt_q) : wr.addr;
    wdata    = init_we ? init_val : wr.data;
    we_a     = init_we || (wr.we && cur_q);
    we_b     = init_we || (wr.we && !cur_q);
  end

  jgr_ram #(.Width(jgr_pkg::VALUE_BITS), .Depth(jgr_pkg::CELLS)) u_grid_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata_a)
  );

  jgr_ram #(.Width(jgr_pkg::VALUE_BITS), .Depth(jgr_pkg::CELLS)) u_grid_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata_b)
  );

  jgr_stencil u_stencil (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .beat_i (beat_q),
    .data_i (rdata_cur),
    .size_i (size_n),
    .prec_i (prec_q),
    .wr_o   (wr)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= jgr_pkg::StIdle;
      cur_q       <= 1'b0;
      sweeps_q    <= '0;
      settled_q   <= 1'b0;
      acc_q       <= 1'b0;
      gs_q        <= jgr_pkg::GridSizeReset;
      bnd_q       <= jgr_pkg::BoundaryReset;
      prec_q      <= jgr_pkg::PrecisionReset;
      cnt_q       <= '0;
      x_q         <= '0;
      y_q         <= '0;
      rd_ok_q     <= 1'b0;
      out_valid_q <= 1'b0;
      beat_q      <= '0;
    end else begin
      state_q <= state_d;
      beat_q  <= beat_d;

      if (cfg_we_i) begin
        case (cfg_addr_i)
          jgr_pkg::CfgGridSize:  gs_q <= cfg_wdata_i[jgr_pkg::GS_W-1:0];
          jgr_pkg::CfgBoundary:  bnd_q <= cfg_wdata_i;
          jgr_pkg::CfgPrecision: prec_q <= cfg_wdata_i[jgr_pkg::PREC_W-1:0];
          default: begin
          end
        endcase
      end

      if (cmd_fire) begin
        cnt_q <= '0;
        x_q   <= '0;
        y_q   <= '0;
      end else if (init_we || issue) begin
        cnt_q <= cnt_q + 1'b1;
        if (x_q == jgr_pkg::COORD_W'(jgr_pkg::GRID_MAX - 1)) begin
          x_q <= '0;
          y_q <= y_q + 1'b1;
        end else begin
          x_q <= x_q + 1'b1;
        end
      end

      if (cmd_fire) begin
        rd_ok_q <= (cmd_i.func == jgr_pkg::FuncRead) && rd_range;
      end

      if (cmd_fire && (cmd_i.func == jgr_pkg::FuncSweep)) begin
        acc_q <= 1'b1;
      end else if (wr.change) begin
        acc_q <= 1'b0;
      end

      if (init_we && init_last) begin
        cur_q     <= 1'b0;
        sweeps_q  <= '0;
        settled_q <= 1'b0;
      end else if (wr.last) begin
        cur_q     <= !cur_q;
        settled_q <= acc_q && !wr.change;
        if (sweeps_q != '1) begin
          sweeps_q <= sweeps_q + 1'b1;
        end
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == jgr_pkg::StRdWait) begin
      cell_q <= rd_ok_q ? jgr_pkg::DATA_W'(rdata_cur) : '0;
    end else if (cmd_fire) begin
      cell_q <= '0;
    end
    if (out_load) begin
      out_cell_q  <= cell_q;
      out_conv_q  <= settled_q;
      out_count_q <= sweeps_q;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.cell_value  = out_cell_q;
  assign res_o.converged   = out_conv_q;
  assign res_o.sweep_count = out_count_q;

  a_wr_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr.we |-> (state_q == jgr_pkg::StSweep || state_q == jgr_pkg::StDrain))
    else $error("grid write-back outside a sweep");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sweeps_q != $past(sweeps_q)) |->
      (sweeps_q == $past(sweeps_q) + 16'd1 || sweeps_q == '0))
    else $error("sweep count moved by other than one");

  a_flip_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_q != $past(cur_q)) |-> ($past(wr.last) || $past(state_q) == jgr_pkg::StInit))
    else $error("current store changed without a finished sweep or initialise");

endmodule
